[hw/rtl/fab_pkg.sv]
// Package for the first-fit block allocator.
// Holds field widths, request codes, saturation limits and the control state type.
// No dependencies.
`default_nettype none

package fab_pkg;

   localparam int DEF_NUM_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   localparam int BLOCK_W  = 4;
   localparam int AMOUNT_W = 16;
   localparam int LEFT_W   = 16;
   localparam int TOTAL_W  = 20;

   localparam logic [63:0] LEFT_MAX  = 64'h0000_0000_0000_FFFF;
   localparam logic [63:0] TOTAL_MAX = 64'h0000_0000_000F_FFFF;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCAN    = 4'b0010,
      ST_LOAD_RD = 4'b0100,
      ST_LOAD_WR = 4'b1000
   } state_type;

   // read and write strobes toward the free-size store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/fab_store.sv]
// Free-size store: one synchronous memory with a registered read port and one write port.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on fab_pkg.
`default_nettype none

module fab_store #(
   parameter int NUM_BLOCKS = fab_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fab_pkg::DEF_SIZE_BITS,
   parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  fab_pkg::store_ctl_type     ctl,
   input  wire  [IDX_W-1:0]           rd_addr,
   input  wire  [IDX_W-1:0]           wr_addr,
   input  wire  [SIZE_BITS-1:0]       wr_data,
   output logic [SIZE_BITS-1:0]       rd_data
);

   logic [SIZE_BITS-1:0]  mem_array [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] written_ff;
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_written_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff    <= mem_array[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (ctl.wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[hw/rtl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: request sequencer, running free sum,
// result register. Depends on fab_pkg and fab_store.
//
//   channel  ports (after the prefix)                                 direction
//   req      valid stall type block_number amount                     in (stall out)
//   rsp      valid stall granted chosen_block left_in_block total_free out (stall in)
//
// A load reads the old size, then writes back the new size and registers the result.
// An allocate reads one block per cycle from the store and checks each one the cycle
// after; it finishes at the first block that fits, or after the last block on a miss.
// Reset clears the store at once through per-block valid bits; no sweep is needed.
// One item is in work at a time; a new one is taken while the last result waits.
// A stalled result holds the finishing step until the result register frees.
`default_nettype none

module first_fit_block_allocator #(
   parameter int NUM_BLOCKS = fab_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fab_pkg::DEF_SIZE_BITS
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_type,
   input  wire  [fab_pkg::BLOCK_W-1:0]   req_block_number,
   input  wire  [fab_pkg::AMOUNT_W-1:0]  req_amount,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_granted,
   output logic [fab_pkg::BLOCK_W-1:0]   rsp_chosen_block,
   output logic [fab_pkg::LEFT_W-1:0]    rsp_left_in_block,
   output logic [fab_pkg::TOTAL_W-1:0]   rsp_total_free
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W = SIZE_BITS + IDX_W;

   fab_pkg::state_type state_ff, state_in;

   logic                          type_ff;
   logic [fab_pkg::BLOCK_W-1:0]   block_ff;
   logic [fab_pkg::AMOUNT_W-1:0]  amount_ff;
   logic [CNT_W-1:0]              scan_idx_ff, scan_idx_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          granted_ff, granted_in;
   logic [fab_pkg::BLOCK_W-1:0]   chosen_ff, chosen_in;
   logic [fab_pkg::LEFT_W-1:0]    left_ff, left_in;
   logic [fab_pkg::TOTAL_W-1:0]   total_ff, total_in;

   fab_pkg::store_ctl_type        store_ctl;
   logic [IDX_W-1:0]              rd_addr;
   logic [IDX_W-1:0]              wr_addr;
   logic [SIZE_BITS-1:0]          wr_data;
   logic [SIZE_BITS-1:0]          rd_data;

   logic                          req_accept;
   logic                          out_free;
   logic                          load_in_range;
   logic [IDX_W-1:0]              load_idx;
   logic [SIZE_BITS-1:0]          load_value;
   logic [31:0]                   amount_ext;
   logic [31:0]                   data_ext;
   logic [31:0]                   diff_ext;
   logic [31:0]                   idx_ext;
   logic                          fit;
   logic                          last_chk;
   logic [63:0]                   new_size_ext;
   logic [63:0]                   sum_next_ext;
   logic [fab_pkg::LEFT_W-1:0]    left_sat;
   logic [fab_pkg::TOTAL_W-1:0]   total_next_sat;
   logic [fab_pkg::TOTAL_W-1:0]   total_cur_sat;

   fab_store #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != fab_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // datapath shared by load and allocate
   assign load_in_range = (32'(block_ff) < NUM_BLOCKS);
   assign load_idx      = IDX_W'(block_ff);
   assign load_value    = SIZE_BITS'(amount_ff);
   assign amount_ext    = 32'(amount_ff);
   assign data_ext      = 32'(rd_data);
   assign diff_ext      = data_ext - amount_ext;
   assign idx_ext       = 32'(chk_idx_ff);
   assign fit           = (amount_ext <= data_ext);
   assign last_chk      = (chk_idx_ff == IDX_W'(NUM_BLOCKS - 1));

   always_comb begin
      if (type_ff == fab_pkg::REQ_LOAD) begin
         new_size_ext = 64'(load_value);
         sum_next_ext = 64'(sum_ff - SUM_W'(rd_data) + SUM_W'(load_value));
      end else begin
         new_size_ext = 64'(diff_ext[SIZE_BITS-1:0]);
         sum_next_ext = 64'(sum_ff - SUM_W'(amount_ff));
      end
   end

   assign left_sat       = (new_size_ext > fab_pkg::LEFT_MAX) ?
                           fab_pkg::LEFT_MAX[fab_pkg::LEFT_W-1:0] :
                           new_size_ext[fab_pkg::LEFT_W-1:0];
   assign total_next_sat = (sum_next_ext > fab_pkg::TOTAL_MAX) ?
                           fab_pkg::TOTAL_MAX[fab_pkg::TOTAL_W-1:0] :
                           sum_next_ext[fab_pkg::TOTAL_W-1:0];
   assign total_cur_sat  = (64'(sum_ff) > fab_pkg::TOTAL_MAX) ?
                           fab_pkg::TOTAL_MAX[fab_pkg::TOTAL_W-1:0] :
                           sum_ff[fab_pkg::TOTAL_W-1:0];

   assign wr_data = new_size_ext[SIZE_BITS-1:0];

   always_comb begin
      state_in        = state_ff;
      scan_idx_in     = scan_idx_ff;
      chk_vld_in      = chk_vld_ff;
      chk_idx_in      = chk_idx_ff;
      sum_in          = sum_ff;
      store_ctl.rd_en = 1'b0;
      store_ctl.wr_en = 1'b0;
      rd_addr         = scan_idx_ff[IDX_W-1:0];
      wr_addr         = chk_idx_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      granted_in      = granted_ff;
      chosen_in       = chosen_ff;
      left_in         = left_ff;
      total_in        = total_ff;

      case (state_ff)
         fab_pkg::ST_IDLE: begin
            if (req_accept) begin
               scan_idx_in = '0;
               chk_vld_in  = 1'b0;
               state_in    = (req_type == fab_pkg::REQ_LOAD) ?
                             fab_pkg::ST_LOAD_RD : fab_pkg::ST_SCAN;
            end
         end
         fab_pkg::ST_LOAD_RD: begin
            store_ctl.rd_en = 1'b1;
            rd_addr         = load_idx;
            state_in        = fab_pkg::ST_LOAD_WR;
         end
         fab_pkg::ST_LOAD_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               chosen_in    = block_ff;
               if (load_in_range) begin
                  store_ctl.wr_en = 1'b1;
                  wr_addr         = load_idx;
                  sum_in          = sum_next_ext[SUM_W-1:0];
                  granted_in      = 1'b1;
                  left_in         = left_sat;
                  total_in        = total_next_sat;
               end else begin
                  granted_in = 1'b0;
                  left_in    = '0;
                  total_in   = total_cur_sat;
               end
               state_in = fab_pkg::ST_IDLE;
            end
         end
         fab_pkg::ST_SCAN: begin
            if (chk_vld_ff && (fit || last_chk)) begin
               // hold the checked entry until the result register frees
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  chk_vld_in   = 1'b0;
                  if (fit) begin
                     store_ctl.wr_en = 1'b1;
                     sum_in          = sum_next_ext[SUM_W-1:0];
                     granted_in      = 1'b1;
                     chosen_in       = idx_ext[fab_pkg::BLOCK_W-1:0];
                     left_in         = left_sat;
                     total_in        = total_next_sat;
                  end else begin
                     granted_in = 1'b0;
                     chosen_in  = '0;
                     left_in    = '0;
                     total_in   = total_cur_sat;
                  end
                  state_in = fab_pkg::ST_IDLE;
               end
            end else begin
               // advance the read stream one block per cycle
               store_ctl.rd_en = (scan_idx_ff < CNT_W'(NUM_BLOCKS));
               chk_vld_in      = store_ctl.rd_en;
               chk_idx_in      = scan_idx_ff[IDX_W-1:0];
               if (store_ctl.rd_en) begin
                  scan_idx_in = scan_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = fab_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fab_pkg::ST_IDLE;
         chk_vld_ff   <= 1'b0;
         scan_idx_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         scan_idx_ff  <= scan_idx_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff   <= req_type;
         block_ff  <= req_block_number;
         amount_ff <= req_amount;
      end
      chk_idx_ff <= chk_idx_in;
      granted_ff <= granted_in;
      chosen_ff  <= chosen_in;
      left_ff    <= left_in;
      total_ff   <= total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_chosen_block  = chosen_ff;
   assign rsp_left_in_block = left_ff;
   assign rsp_total_free    = total_ff;

endmodule

`default_nettype wire
